[hdl/rau_pkg.sv]
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes, widths and the control bundle between the sequencer and
// the shared arithmetic datapath.
// ---------------------------------------------------------------------------
package rau_pkg;

	localparam int OpW  = 16;
	localparam int ResW = 33;
	localparam int MagW = 32;
	localparam int CntW = 6;

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_CMP = 3'd4;

	// Datapath commands from the sequencer
	localparam logic [2:0] DP_IDLE  = 3'd0;
	localparam logic [2:0] DP_LOAD  = 3'd1; // load gcd operands x=|n|, y=|d|
	localparam logic [2:0] DP_MODST = 3'd2; // start x % y
	localparam logic [2:0] DP_MODIT = 3'd3; // one restoring step
	localparam logic [2:0] DP_SWAP  = 3'd4; // x <= y, y <= remainder
	localparam logic [2:0] DP_DIVST = 3'd5; // start |n| / g, or |d| / g when sel_den is set
	localparam logic [2:0] DP_DIVN  = 3'd6; // store quotient as numerator
	localparam logic [2:0] DP_DIVD  = 3'd7; // store quotient as denominator

	typedef struct packed {
		logic [2:0] cmd;
		logic       sel_den; // dividend for DP_DIVST: 0 numerator, 1 denominator
	} dp_ctrl_t;

	typedef struct packed {
		logic y_zero;   // gcd divisor is zero, x holds the gcd
		logic g_gt1;    // gcd greater than one
		logic step_last;// last restoring step of the current division
	} dp_stat_t;

endpackage

[hdl/rau_divider.sv]
// ---------------------------------------------------------------------------
// rau_divider: shared restoring divider and gcd registers
// One quotient bit per cycle over 32-bit magnitudes; serves the Euclid
// remainders and the final exact divisions by the gcd.
// ---------------------------------------------------------------------------
module rau_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rau_pkg::dp_ctrl_t                    ctrl,
	input  logic [rau_pkg::MagW-1:0]             mag_n,
	input  logic [rau_pkg::MagW-1:0]             mag_d,
	output rau_pkg::dp_stat_t                    stat,
	output logic [rau_pkg::MagW-1:0]             quo_num,
	output logic [rau_pkg::MagW-1:0]             quo_den
);

	logic [rau_pkg::MagW-1:0] x_q, y_q, g_q;
	logic [rau_pkg::MagW-1:0] rem_q, quo_q, dvd_q, dvs_q;
	logic [rau_pkg::CntW-1:0] cnt_q;
	logic [rau_pkg::MagW:0]   shifted, diff;
	logic [rau_pkg::MagW-1:0] rem_nx, quo_nx;

	// trial subtract for one restoring step
	assign shifted = {rem_q, dvd_q[rau_pkg::MagW-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign rem_nx  = diff[rau_pkg::MagW] ? shifted[rau_pkg::MagW-1:0] : diff[rau_pkg::MagW-1:0];
	assign quo_nx  = {quo_q[rau_pkg::MagW-2:0], !diff[rau_pkg::MagW]};

	assign stat.y_zero    = (y_q == '0);
	assign stat.g_gt1     = (x_q > rau_pkg::MagW'(1));
	assign stat.step_last = (cnt_q == rau_pkg::CntW'(rau_pkg::MagW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.cmd == rau_pkg::DP_MODST || ctrl.cmd == rau_pkg::DP_DIVST) begin
			cnt_q <= '0;
		end else if (ctrl.cmd == rau_pkg::DP_MODIT) begin
			cnt_q <= cnt_q + rau_pkg::CntW'(1);
		end
	end

	// datapath registers; SWAP, DIVN and DIVD each do the last restoring step
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			rau_pkg::DP_LOAD: begin
				x_q <= mag_n;
				y_q <= mag_d;
			end
			rau_pkg::DP_MODST: begin
				rem_q <= '0;
				quo_q <= '0;
				dvd_q <= x_q;
				dvs_q <= y_q;
			end
			rau_pkg::DP_DIVST: begin
				rem_q <= '0;
				quo_q <= '0;
				dvd_q <= ctrl.sel_den ? mag_d : mag_n;
				dvs_q <= g_q;
			end
			rau_pkg::DP_MODIT: begin
				dvd_q <= {dvd_q[rau_pkg::MagW-2:0], 1'b0};
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
			rau_pkg::DP_SWAP: begin
				x_q <= y_q;
				y_q <= rem_nx;
				g_q <= y_q;
			end
			rau_pkg::DP_DIVN: quo_num <= quo_nx;
			rau_pkg::DP_DIVD: quo_den <= quo_nx;
			default: begin
			end
		endcase
	end

endmodule

[hdl/rau_seq.sv]
// ---------------------------------------------------------------------------
// rau_seq: sequencer for the rational arithmetic unit
// Walks Euclid's algorithm on the shared divider, then, when the gcd is
// greater than one, divides both magnitudes by the gcd.
// ---------------------------------------------------------------------------
module rau_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,    // reducible result loaded
	input  rau_pkg::dp_stat_t stat,
	output rau_pkg::dp_ctrl_t ctrl,
	output logic              done      // pulses when reduction finished
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TEST  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_DIVN  = 3'd3;
	localparam logic [2:0] S_DIVD  = 3'd4;
	localparam logic [2:0] S_SETUP = 3'd5;
	localparam logic [2:0] S_SETD  = 3'd6; // start the denominator pass
	localparam logic [2:0] S_FIN   = 3'd7; // both quotients stored

	logic [2:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_TEST;
				S_TEST: begin
					if (stat.y_zero) state_q <= stat.g_gt1 ? S_SETUP : S_IDLE;
					else state_q <= S_MOD;
				end
				S_MOD: if (stat.step_last) state_q <= S_TEST;
				S_SETUP: state_q <= S_DIVN;
				S_DIVN: if (stat.step_last) state_q <= S_SETD;
				S_SETD: state_q <= S_DIVD;
				S_DIVD: if (stat.step_last) state_q <= S_FIN;
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode; a divide pass starts in the cycle before its steps
	always_comb begin
		ctrl.cmd     = rau_pkg::DP_IDLE;
		ctrl.sel_den = 1'b0;
		done         = 1'b0;
		case (state_q)
			S_IDLE: if (start) ctrl.cmd = rau_pkg::DP_LOAD;
			S_TEST: begin
				if (stat.y_zero) begin
					done = !stat.g_gt1;
				end else begin
					ctrl.cmd = rau_pkg::DP_MODST;
				end
			end
			S_MOD: ctrl.cmd = stat.step_last ? rau_pkg::DP_SWAP : rau_pkg::DP_MODIT;
			S_SETUP: ctrl.cmd = rau_pkg::DP_DIVST;
			S_DIVN: begin
				if (stat.step_last) begin
					ctrl.cmd     = rau_pkg::DP_DIVN;
				end else begin
					ctrl.cmd     = rau_pkg::DP_MODIT;
				end
			end
			S_SETD: begin
				ctrl.cmd     = rau_pkg::DP_DIVST;
				ctrl.sel_den = 1'b1;
			end
			S_DIVD: begin
				if (stat.step_last) begin
					ctrl.cmd = rau_pkg::DP_DIVD;
				end else begin
					ctrl.cmd = rau_pkg::DP_MODIT;
				end
			end
			S_FIN: done = 1'b1;
			default: begin
			end
		endcase
	end

endmodule

[hdl/rational_arithmetic_unit.sv]
// Result paths: errors and unused codes after the first product, compare
// after the second, a zero numerator without reduction, a gcd of one without
// the divisions, otherwise Euclid at one quotient bit per cycle and then the
// two exact divisions by the gcd. Throughput: one item at a time; in_stall is
// high from the cycle after accept until the result beat is taken.
// Reset: arst_n asynchronously clears the sequencers and valid flags.
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: exact arithmetic on two signed 16-bit fractions
// Cross multiplies on a shared multiplier, reduces by the gcd on a shared
// restoring divider, and compares by cross products.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  kind,
	input  logic signed [15:0]          num_a,
	input  logic signed [15:0]          den_a,
	input  logic signed [15:0]          num_b,
	input  logic signed [15:0]          den_b,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [32:0]          result_num,
	output logic signed [32:0]          result_den,
	output logic                        is_less,
	output logic                        is_equal,
	output logic                        is_greater,
	output logic                        error
);

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_P1   = 3'd1; // first product
	localparam logic [2:0] T_P2   = 3'd2; // second product
	localparam logic [2:0] T_P3   = 3'd3; // third product, form result
	localparam logic [2:0] T_RED  = 3'd4; // gcd reduction
	localparam logic [2:0] T_OUT  = 3'd5; // hold result

	logic [2:0]         st_q;
	logic [2:0]         kind_q;
	logic signed [15:0] na_q, da_q, nb_q, db_q;
	logic signed [31:0] p1_q, p2_q;
	logic signed [32:0] rn_q, rd_q;
	logic               rn_neg_q, rd_neg_q;
	logic signed [15:0] mul_a, mul_b;
	logic signed [31:0] prod;
	logic               accept, done;
	logic [rau_pkg::MagW-1:0] mag_n, mag_d, quo_num, quo_den;
	rau_pkg::dp_ctrl_t  ctrl;
	rau_pkg::dp_stat_t  stat;
	logic               bad;
	logic               busy_q;
	logic               seq_go_q;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != T_IDLE);

	// one shared 16x16 multiplier, operands picked by step
	always_comb begin
		mul_a = na_q;
		mul_b = db_q;
		case (st_q)
			T_P1: begin
				mul_a = na_q;
				mul_b = (kind_q == rau_pkg::KIND_MUL) ? nb_q : db_q;
			end
			T_P2: begin
				mul_a = (kind_q == rau_pkg::KIND_DIV) ? da_q : nb_q;
				mul_b = (kind_q == rau_pkg::KIND_DIV) ? nb_q : da_q;
			end
			T_P3: begin
				mul_a = da_q;
				mul_b = db_q;
			end
			default: begin
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign bad = (da_q == '0) || (db_q == '0) || (kind_q == rau_pkg::KIND_DIV && nb_q == '0);

	// magnitudes of the unreduced result for the divider (fit in 32 bits)
	assign mag_n = rn_q[32] ? rau_pkg::MagW'(-rn_q) : rn_q[31:0];
	assign mag_d = rd_q[32] ? rau_pkg::MagW'(-rd_q) : rd_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= T_IDLE;
			out_valid <= 1'b0;
			busy_q    <= 1'b0;
		end else begin
			case (st_q)
				T_IDLE: if (accept) st_q <= T_P1;
				T_P1: begin
					if (kind_q > rau_pkg::KIND_CMP || bad) begin
						st_q      <= T_OUT;
						out_valid <= 1'b1;
					end else begin
						st_q <= T_P2;
					end
				end
				T_P2: begin
					if (kind_q == rau_pkg::KIND_CMP) begin
						st_q      <= T_OUT;
						out_valid <= 1'b1;
					end else begin
						st_q <= T_P3;
					end
				end
				T_P3: st_q <= T_RED;
				T_RED: begin
					if (!busy_q) begin
						if (rn_q == '0) begin
							st_q      <= T_OUT;
							out_valid <= 1'b1;
						end else begin
							busy_q <= 1'b1;
						end
					end else if (done) begin
						busy_q    <= 1'b0;
						st_q      <= T_OUT;
						out_valid <= 1'b1;
					end
				end
				T_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						st_q      <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			na_q   <= num_a;
			da_q   <= den_a;
			nb_q   <= num_b;
			db_q   <= den_b;
		end
		case (st_q)
			T_P1: begin
				p1_q       <= prod;
				result_num <= '0;
				result_den <= '0;
				is_less    <= 1'b0;
				is_equal   <= 1'b0;
				is_greater <= 1'b0;
				error      <= (kind_q <= rau_pkg::KIND_CMP) && bad;
			end
			T_P2: begin
				p2_q <= prod;
				if (kind_q == rau_pkg::KIND_CMP) begin
					// reverse the order when the denominators differ in sign
					is_equal   <= (p1_q == prod);
					is_less    <= (p1_q != prod) && ((p1_q < prod) != (da_q[15] ^ db_q[15]));
					is_greater <= (p1_q != prod) && ((p1_q < prod) == (da_q[15] ^ db_q[15]));
				end
			end
			T_P3: begin
				case (kind_q)
					rau_pkg::KIND_ADD: rn_q <= 33'(p1_q) + 33'(p2_q);
					rau_pkg::KIND_SUB: rn_q <= 33'(p1_q) - 33'(p2_q);
					rau_pkg::KIND_MUL: rn_q <= 33'(p1_q);
					default:           rn_q <= 33'(p1_q);
				endcase
				rd_q <= (kind_q == rau_pkg::KIND_DIV) ? 33'(p2_q) : 33'(prod);
			end
			T_RED: begin
				if (!busy_q) begin
					rn_neg_q   <= rn_q[32];
					rd_neg_q   <= rd_q[32];
					result_num <= rn_q;
					result_den <= rd_q;
				end else if (done && stat.g_gt1) begin
					// both quotients are stored; put the original signs back
					result_num <= rn_neg_q ? -{1'b0, quo_num} : {1'b0, quo_num};
					result_den <= rd_neg_q ? -{1'b0, quo_den} : {1'b0, quo_den};
				end
			end
			default: begin
			end
		endcase
	end

	rau_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (busy_q && !seq_go_q),
		.stat   (stat),
		.ctrl   (ctrl),
		.done   (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seq_go_q <= 1'b0;
		else         seq_go_q <= busy_q && !done;
	end

	rau_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.mag_n   (mag_n),
		.mag_d   (mag_d),
		.stat    (stat),
		.quo_num (quo_num),
		.quo_den (quo_den)
	);

endmodule

[hdl/rau_checker.sv]
// ---------------------------------------------------------------------------
// rau_checker: port-level checks for the rational arithmetic unit
// Watches handshakes and result flag consistency.
// ---------------------------------------------------------------------------
module rau_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic is_less,
	input logic is_equal,
	input logic is_greater,
	input logic error
);

	// at most one relation flag per beat
	a_onerel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({is_less, is_equal, is_greater}))
		else $error("more than one relation flag");

	// an error beat carries no relation
	a_errclean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> !(is_less || is_equal || is_greater))
		else $error("relation flag with error");

	// no new input while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// a stalled result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.is_less    (is_less),
	.is_equal   (is_equal),
	.is_greater (is_greater),
	.error      (error)
);
